// ===== sv/substring_occurrence_counter_unit_defines.svh =====
// Assertion macros for the substring occurrence counter.
// Used by the top level; no other dependencies.
`ifndef SUBSTRING_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SOCU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SOCU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SOCU_ASSERT(lbl, prop, msg)
`define SOCU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== sv/socu_pkg.sv =====
// Shared types and constants for the substring occurrence counter.
// No dependencies.
package socu_pkg;

    localparam int BYTE_W                = 8;
    localparam int PAT_W                 = 64;
    localparam int LEN_W                 = 4;
    localparam int DATA_W                = 64;
    localparam int ADDR_W                = 4;
    localparam int MATCH_W               = 20;
    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int COUNT_WIDTH_DEF       = 20;

    typedef enum logic {
        REG_PATTERN = 1'b0,
        REG_LENGTH  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic fire;
        logic last;
        logic hit;
    } t_step;

    typedef struct packed {
        logic record_open;
    } t_status;

endpackage

// ===== sv/socu_stream_if.sv =====
// Stream channel interfaces (byte input, count output).
// Depends on socu_pkg.
interface socu_in_if;
    logic                        valid;
    logic                        ready;
    logic [socu_pkg::BYTE_W-1:0] data_byte;
    logic                        last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface socu_out_if;
    logic                         valid;
    logic                         ready;
    logic [socu_pkg::MATCH_W-1:0] match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

// ===== sv/substring_occurrence_counter_unit.sv =====
// Substring occurrence counter: one byte per transaction, count per record.
// One byte per cycle while the skid is empty; the cell-chain compare is combinational.
// A record's count is written into the result buffer when its last byte is taken.
// A two-entry result buffer keeps input flowing while a count waits.
// Reset: synchronous, active low; clears record state, buffer flags and config.
`include "substring_occurrence_counter_unit_defines.svh"

module substring_occurrence_counter_unit #(
    parameter int MAX_PATTERN_BYTES = socu_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int COUNT_WIDTH       = socu_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    socu_in_if.sink                     i_in,
    socu_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [socu_pkg::ADDR_W-1:0] paddr,
    input  logic [socu_pkg::DATA_W-1:0] pwdata,
    output logic [socu_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int EXT_W = (COUNT_WIDTH > socu_pkg::MATCH_W) ? COUNT_WIDTH
                                                              : socu_pkg::MATCH_W;

    // configuration registers
    logic [socu_pkg::PAT_W-1:0] r_pattern;
    logic [socu_pkg::LEN_W-1:0] r_pat_len;
    logic [socu_pkg::LEN_W-1:0] eff_len;
    socu_pkg::t_reg_idx         cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = socu_pkg::t_reg_idx'(paddr[socu_pkg::ADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_pat_len <= socu_pkg::LEN_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                socu_pkg::REG_PATTERN: r_pattern <= pwdata;
                socu_pkg::REG_LENGTH:  r_pat_len <= pwdata[socu_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            socu_pkg::REG_PATTERN: prdata = r_pattern;
            socu_pkg::REG_LENGTH:  prdata = socu_pkg::DATA_W'(r_pat_len);
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        if (r_pat_len == '0) begin
            eff_len = socu_pkg::LEN_W'(1);
        end else if (r_pat_len > socu_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
            eff_len = socu_pkg::LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            eff_len = r_pat_len;
        end
    end

    // window cell chain
    logic                        fire;
    logic [socu_pkg::BYTE_W-1:0] chain [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] hits;

    assign fire     = i_in.valid && i_in.ready;
    assign chain[0] = i_in.data_byte;

    for (genvar a = 0; a < MAX_PATTERN_BYTES; a++) begin : g_cell
        socu_cell #(
            .AGE (a)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (fire),
            .i_byte    (chain[a]),
            .i_pattern (r_pattern),
            .i_len     (eff_len),
            .o_byte    (chain[a+1]),
            .o_hit     (hits[a])
        );
    end

    // record state
    socu_pkg::t_step        step;
    socu_pkg::t_status      status;
    logic [COUNT_WIDTH-1:0] step_count;

    assign step.fire = fire;
    assign step.last = i_in.last;
    assign step.hit  = &hits;

    socu_count #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .COUNT_WIDTH       (COUNT_WIDTH)
    ) u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_len    (eff_len),
        .o_count  (step_count),
        .o_status (status)
    );

    // two-entry result buffer
    logic [EXT_W-1:0]             count_ext;
    logic [socu_pkg::MATCH_W-1:0] push_data;
    logic                         push, pop;
    logic                         r_head_valid, n_head_valid;
    logic                         r_skid_valid, n_skid_valid;
    logic [socu_pkg::MATCH_W-1:0] r_head, r_skid;

    assign count_ext = EXT_W'(step_count);
    assign push_data = count_ext[socu_pkg::MATCH_W-1:0];
    assign push      = fire && i_in.last;
    assign pop       = r_head_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            n_head_valid = r_skid_valid || push;
            n_skid_valid = r_skid_valid && push;
        end else if (push) begin
            n_head_valid = 1'b1;
            n_skid_valid = r_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                if (push) begin
                    r_skid <= push_data;
                end
            end else if (push) begin
                r_head <= push_data;
            end
        end else if (push) begin
            if (r_head_valid) begin
                r_skid <= push_data;
            end else begin
                r_head <= push_data;
            end
        end
    end

    assign o_out.valid       = r_head_valid;
    assign o_out.match_count = r_head;

    `SOCU_ASSERT(a_skid_needs_head, r_skid_valid |-> r_head_valid, "skid full with empty head")
    `SOCU_ASSERT(a_last_closes_record, (fire && i_in.last) |=> !status.record_open, "record not cleared after last byte")
    `SOCU_ASSERT(a_byte_opens_record, (fire && !i_in.last) |=> status.record_open, "record not open after a byte")
    `SOCU_ASSERT_RST(a_reset_empties, !i_rst_n |=> (!r_head_valid && !r_skid_valid), "result buffer not empty after reset")

endmodule

// ===== sv/socu_cell.sv =====
// One window cell: holds a byte of history and compares its incoming byte
// against the pattern byte for its age. Depends on socu_pkg.
module socu_cell #(
    parameter int AGE = 0
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [socu_pkg::BYTE_W-1:0] i_byte,
    input  logic [socu_pkg::PAT_W-1:0]  i_pattern,
    input  logic [socu_pkg::LEN_W-1:0]  i_len,
    output logic [socu_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_hit
);

    localparam logic [socu_pkg::LEN_W-1:0] AGE_L = socu_pkg::LEN_W'(AGE);

    logic [socu_pkg::BYTE_W-1:0] r_byte;
    logic [socu_pkg::LEN_W-1:0]  sel;
    logic [socu_pkg::BYTE_W-1:0] want;
    logic                        active;

    always_comb begin
        active = AGE_L < i_len;
        sel    = i_len - AGE_L - socu_pkg::LEN_W'(1);
        want   = i_pattern[{sel[2:0], 3'b000} +: socu_pkg::BYTE_W];
        o_hit  = !active || (i_byte == want);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== sv/socu_count.sv =====
// Record state: fill count, skip counter and saturating match count.
// Depends on socu_pkg.
module socu_count #(
    parameter int MAX_PATTERN_BYTES = socu_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int COUNT_WIDTH       = socu_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  socu_pkg::t_step            i_step,
    input  logic [socu_pkg::LEN_W-1:0] i_len,
    output logic [COUNT_WIDTH-1:0]     o_count,
    output socu_pkg::t_status          o_status
);

    localparam int SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int SKIP_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [SEEN_W-1:0]      r_seen,  n_seen;
    logic [SKIP_W-1:0]      r_skip,  n_skip;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [SEEN_W-1:0]      seen_inc;
    logic [SKIP_W-1:0]      step_skip;
    logic [COUNT_WIDTH-1:0] step_count;

    always_comb begin
        seen_inc   = (r_seen < SEEN_W'(MAX_PATTERN_BYTES)) ? r_seen + SEEN_W'(1) : r_seen;
        step_skip  = r_skip;
        step_count = r_count;
        if (r_skip != '0) begin
            step_skip = r_skip - SKIP_W'(1);
        end else if ((socu_pkg::LEN_W'(seen_inc) >= i_len) && i_step.hit) begin
            if (!(&r_count)) begin
                step_count = r_count + COUNT_WIDTH'(1);
            end
            step_skip = SKIP_W'(i_len - socu_pkg::LEN_W'(1));
        end

        n_seen  = r_seen;
        n_skip  = r_skip;
        n_count = r_count;
        if (i_step.fire) begin
            if (i_step.last) begin
                n_seen  = '0;
                n_skip  = '0;
                n_count = '0;
            end else begin
                n_seen  = seen_inc;
                n_skip  = step_skip;
                n_count = step_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_skip  <= '0;
            r_count <= '0;
        end else begin
            r_seen  <= n_seen;
            r_skip  <= n_skip;
            r_count <= n_count;
        end
    end

    assign o_count              = step_count;
    assign o_status.record_open = (r_seen != '0);

endmodule
